// ----- hdl/bsort_pkg.sv -----
// Shared types and constants of the bubble sorter.
// Holds the transaction payload structs, register indexes and the sequencer state type.
// No dependencies.
package bsort_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields and the configuration port
  localparam int FIELD_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DESCENDING = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED     = 4'd1;

  // Input transaction payload
  typedef struct packed {
    logic [FIELD_W-1:0] key_in;
    logic               last_in;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [FIELD_W-1:0] key_out;
    logic               last_out;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_RD,
    ST_PASS_LD,
    ST_PASS_CMP,
    ST_PASS_END,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/bsort_ram.sv -----
// Key memory of the bubble sorter: one write port, one read port, registered read data.
// Depends on nothing; depth and width come from the top level.
module bsort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bubble_sorter.sv -----
// Bubble sorter top level: key loading, in-place sort sequencer and result output.
// Depends on bsort_pkg and bsort_ram.
//
// Keys arrive one per transaction (start high while busy is low) and are written to an
// on-chip key memory; busy stays low while loading, so a new key can be taken every cycle.
// Keys beyond CAPACITY are dropped. The transaction marked last_in raises busy and starts
// the sort: for a set of n keys it runs n-1 passes, each one shorter than the last, with
// one compare-and-swap per cycle within a pass through the single read port of the key
// memory, with the carried key held in a register and written back at the pass end.
// The sorted keys then go out on out_item one per cycle, each marked by out_strobe for
// exactly one cycle, the final one with last_out set; the receiver cannot stall, so it
// must take a result in every cycle that out_strobe is high. Busy drops as the final
// result is issued, and a new set may start while that result is still shown. Order and
// signedness are read from the configuration registers when the sort runs; write them
// only while busy is low and no result is pending. Equal keys keep their arrival order.
module bubble_sorter #(
  parameter int CAPACITY  = bsort_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bsort_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               start,
  output logic                               busy,
  input  bsort_pkg::in_item_t                in_item,
  // Result channel
  output logic                               out_strobe,
  output bsort_pkg::out_item_t               out_item,
  // Configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsort_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bsort_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [KEY_WIDTH-1:0] MSB_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  bsort_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        end_r, end_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        emit_idx_r, emit_idx_nxt;
  logic [KEY_WIDTH-1:0] carry_r, carry_nxt;
  logic                 out_pend_r, out_pend_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 desc_r, desc_nxt;
  logic                 sign_r, sign_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] rd_data;

  logic                 in_accept;
  logic                 store_full;
  logic [CW-1:0]        count_after;
  logic [CW-1:0]        count_m1;
  logic [KEY_WIDTH-1:0] key_load;
  logic [KEY_WIDTH-1:0] ord_carry;
  logic [KEY_WIDTH-1:0] ord_next;
  logic                 swap;
  logic                 emit_last;

  bsort_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Handshake and load helpers
  assign busy        = (state_r != bsort_pkg::ST_IDLE);
  assign in_accept   = start && !busy;
  assign store_full  = (count_r == CW'(CAPACITY));
  assign count_after = store_full ? count_r : count_r + CW'(1);
  assign count_m1    = count_after - CW'(1);
  assign key_load    = KEY_WIDTH'(in_item.key_in);

  // Compare: bias the sign bit for signed keys, then compare unsigned
  assign ord_carry = carry_r ^ (sign_r ? MSB_MASK : '0);
  assign ord_next  = rd_data ^ (sign_r ? MSB_MASK : '0);
  assign swap      = desc_r ? (ord_carry < ord_next) : (ord_carry > ord_next);

  assign emit_last = ((CW'(emit_idx_r) + CW'(1)) == count_r);

  // Configuration registers: always ready, ignore unknown indexes
  assign cfg_ready = 1'b1;

  always_comb begin
    desc_nxt = desc_r;
    sign_nxt = sign_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsort_pkg::REG_DESCENDING: desc_nxt = cfg_data[0];
        bsort_pkg::REG_SIGNED:     sign_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: load, sort passes over the key memory, emit
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    end_nxt      = end_r;
    pos_nxt      = pos_r;
    emit_idx_nxt = emit_idx_r;
    carry_nxt    = carry_r;
    out_pend_nxt = 1'b0;
    out_last_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = carry_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    unique case (state_r)
      bsort_pkg::ST_IDLE: begin
        if (in_accept) begin
          // Store the key unless full
          if (!store_full) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = key_load;
          end
          count_nxt = count_after;
          if (in_item.last_in) begin
            emit_idx_nxt = '0;
            if (count_after > CW'(1)) begin
              end_nxt   = count_m1[AW-1:0];
              state_nxt = bsort_pkg::ST_PASS_RD;
            end else begin
              state_nxt = bsort_pkg::ST_EMIT;
            end
          end
        end
      end
      bsort_pkg::ST_PASS_RD: begin
        // Fetch the head of the pass
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = bsort_pkg::ST_PASS_LD;
      end
      bsort_pkg::ST_PASS_LD: begin
        // Take the head as carried key, fetch its neighbor
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
        carry_nxt = rd_data;
        pos_nxt   = '0;
        state_nxt = bsort_pkg::ST_PASS_CMP;
      end
      bsort_pkg::ST_PASS_CMP: begin
        // Drop the lesser-ranked key at pos, carry the other onward
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = swap ? rd_data : carry_r;
        carry_nxt = swap ? carry_r : rd_data;
        if ((pos_r + AW'(1)) == end_r) begin
          state_nxt = bsort_pkg::ST_PASS_END;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_r + AW'(2);
          pos_nxt   = pos_r + AW'(1);
        end
      end
      bsort_pkg::ST_PASS_END: begin
        // Settle the carried key at the pass end, shorten the next pass
        ram_we    = 1'b1;
        ram_waddr = end_r;
        ram_wdata = carry_r;
        if (end_r == AW'(1)) begin
          state_nxt = bsort_pkg::ST_EMIT;
        end else begin
          end_nxt   = end_r - AW'(1);
          state_nxt = bsort_pkg::ST_PASS_RD;
        end
      end
      bsort_pkg::ST_EMIT: begin
        // Read one sorted key per cycle; the result shows the next cycle
        ram_re       = 1'b1;
        ram_raddr    = emit_idx_r;
        out_pend_nxt = 1'b1;
        out_last_nxt = emit_last;
        if (emit_last) begin
          count_nxt = '0;
          state_nxt = bsort_pkg::ST_IDLE;
        end else begin
          emit_idx_nxt = emit_idx_r + AW'(1);
        end
      end
      default: state_nxt = bsort_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bsort_pkg::ST_IDLE;
      count_r    <= '0;
      out_pend_r <= 1'b0;
      out_last_r <= 1'b0;
      desc_r     <= 1'b0;
      sign_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      out_pend_r <= out_pend_nxt;
      out_last_r <= out_last_nxt;
      desc_r     <= desc_nxt;
      sign_r     <= sign_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    pos_r      <= pos_nxt;
    emit_idx_r <= emit_idx_nxt;
    carry_r    <= carry_nxt;
  end

  // Result transaction straight from registers
  assign out_strobe = out_pend_r;

  always_comb begin
    out_item.key_out  = bsort_pkg::FIELD_W'(rd_data);
    out_item.last_out = out_last_r;
  end

  // Key count never passes the store capacity
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count exceeds capacity");

  // A compare step always lies inside the current pass
  a_pos_in_pass : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsort_pkg::ST_PASS_CMP) |-> (pos_r < end_r))
    else $error("compare position beyond pass end");

  // Every result comes from an emit read
  a_strobe_src : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == bsort_pkg::ST_EMIT))
    else $error("result strobe without emit read");

  // A set-closing transaction makes the block busy
  a_last_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.last_in) |=> busy)
    else $error("busy not raised after last key");

  // The final result is followed by a gap
  a_last_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_out) |=> !out_strobe)
    else $error("result follows final result directly");

endmodule
